FILE: design/alive_counter_sequence_monitor_unit_defines.svh
// Assertion macros shared by the alive counter monitor checker.
// No dependencies; included by the checker file only.
`ifndef ALIVE_COUNTER_SEQUENCE_MONITOR_UNIT_DEFINES_SVH
`define ALIVE_COUNTER_SEQUENCE_MONITOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ACSM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("acsm assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ACSM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("acsm assertion failed");

`endif

FILE: design/acsm_pkg.sv
// Shared types and constants of the alive counter sequence monitor.
// No dependencies; used by every module of the block.
package acsm_pkg;

   localparam int COUNTER_BITS_DEFAULT = 8;
   localparam int ANGLE_BITS_DEFAULT   = 16;
   localparam int QUEUE_DEPTH_DEFAULT  = 2;
   localparam int LIMIT_BITS           = 4;
   localparam int CSR_INDEX_BITS       = 2;

   localparam int                    ANGLE_MIN_RESET = -512;
   localparam int                    ANGLE_MAX_RESET = 511;
   localparam logic [LIMIT_BITS-1:0] SEQ_LIMIT_RESET = 4'd2;
   localparam logic [LIMIT_BITS-1:0] REC_LIMIT_RESET = 4'd3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ANGLE_MIN = 2'd0,
      CSR_ANGLE_MAX = 2'd1,
      CSR_SEQ_LIMIT = 2'd2,
      CSR_REC_LIMIT = 2'd3
   } csr_index_type;

   // Classification made by the front end for each transaction.
   typedef struct packed {
      logic rx_fault;
      logic angle_fault;
   } acsm_flags_type;

   localparam int FLAGS_BITS = $bits(acsm_flags_type);

   // Limits handed from the configuration registers to the back end.
   typedef struct packed {
      logic [LIMIT_BITS-1:0] seq_limit;
      logic [LIMIT_BITS-1:0] rec_limit;
   } acsm_limits_type;

endpackage

FILE: design/alive_counter_sequence_monitor_unit.sv
// Alive counter sequence monitor: each request transaction carries a
// receive-ok flag, an alive counter and a steering angle, and yields exactly
// one response transaction with the angle passed through and the receive,
// angle and recovery fault flags. The block sustains one transaction per
// clock cycle while the response side is not stalled; this rate is set by
// the back end, which updates the sequence state (last counter, mismatch and
// good counts, recovery mode) as it takes each transaction. With an idle
// pipeline a request passes through the queue entry and then the back end's
// result register before its response is offered. A two-entry queue between
// the front and the back lets the request side keep flowing for two
// transactions while the response side stalls. Configuration registers are
// written through the csr port, which is always ready; they should be
// changed only while no transaction is in flight. There is no clearing pass
// after reset.
// Depends on acsm_pkg, acsm_front, acsm_queue and acsm_back.
module alive_counter_sequence_monitor_unit #(
   parameter int COUNTER_BITS = acsm_pkg::COUNTER_BITS_DEFAULT,
   parameter int ANGLE_BITS   = acsm_pkg::ANGLE_BITS_DEFAULT,
   parameter int QUEUE_DEPTH  = acsm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [acsm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ANGLE_BITS-1:0]               csr_data,
   // Request channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_rx_ok,
   input  logic [COUNTER_BITS-1:0]             req_alive_count_in,
   input  logic signed [ANGLE_BITS-1:0]        req_steer_angle_in,
   // Response channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ANGLE_BITS-1:0]        rsp_steer_angle_out,
   output logic                                rsp_fault_flag,
   output logic                                rsp_recovery_active,
   output logic                                rsp_rx_fault,
   output logic                                rsp_angle_fault
);
   import acsm_pkg::*;

   // Queue entry layout: flags, then counter, then angle.
   localparam int ENTRY_BITS = FLAGS_BITS + COUNTER_BITS + ANGLE_BITS;

   logic                    queue_full;
   logic                    queue_push;
   logic                    queue_pop;
   logic                    queue_not_empty;
   acsm_flags_type          push_flags;
   logic [COUNTER_BITS-1:0] push_count;
   logic [ANGLE_BITS-1:0]   push_angle;
   logic [ENTRY_BITS-1:0]   push_entry;
   logic [ENTRY_BITS-1:0]   head_entry;
   acsm_flags_type          head_flags;
   logic [COUNTER_BITS-1:0] head_count;
   logic [ANGLE_BITS-1:0]   head_angle;
   acsm_limits_type         limits;

   // The front end registers the configuration and classifies each request.
   acsm_front #(
      .COUNTER_BITS (COUNTER_BITS),
      .ANGLE_BITS   (ANGLE_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_ok          (req_rx_ok),
      .req_alive_count_in (req_alive_count_in),
      .req_steer_angle_in (req_steer_angle_in),
      .queue_full         (queue_full),
      .queue_push         (queue_push),
      .push_flags         (push_flags),
      .push_count         (push_count),
      .push_angle         (push_angle),
      .limits             (limits)
   );

   assign push_entry = {push_flags, push_count, push_angle};

   acsm_queue #(
      .DATA_BITS (ENTRY_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_entry),
      .pop       (queue_pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_data (head_entry)
   );

   assign head_flags = acsm_flags_type'(head_entry[ENTRY_BITS-1 -: FLAGS_BITS]);
   assign head_count = head_entry[ANGLE_BITS +: COUNTER_BITS];
   assign head_angle = head_entry[ANGLE_BITS-1:0];

   // The back end tracks the counter sequence and holds the response.
   acsm_back #(
      .COUNTER_BITS (COUNTER_BITS),
      .ANGLE_BITS   (ANGLE_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .entry_valid         (queue_not_empty),
      .entry_pop           (queue_pop),
      .entry_flags         (head_flags),
      .entry_count         (head_count),
      .entry_angle         (head_angle),
      .limits              (limits),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_steer_angle_out (rsp_steer_angle_out),
      .rsp_fault_flag      (rsp_fault_flag),
      .rsp_recovery_active (rsp_recovery_active),
      .rsp_rx_fault        (rsp_rx_fault),
      .rsp_angle_fault     (rsp_angle_fault)
   );

endmodule

FILE: design/acsm_front.sv
// Front end: configuration registers, input handshake and angle range check.
// Depends on acsm_pkg.
module acsm_front #(
   parameter int COUNTER_BITS = acsm_pkg::COUNTER_BITS_DEFAULT,
   parameter int ANGLE_BITS   = acsm_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [acsm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ANGLE_BITS-1:0]             csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_rx_ok,
   input  logic [COUNTER_BITS-1:0]           req_alive_count_in,
   input  logic signed [ANGLE_BITS-1:0]      req_steer_angle_in,
   input  logic                              queue_full,
   output logic                              queue_push,
   output acsm_pkg::acsm_flags_type          push_flags,
   output logic [COUNTER_BITS-1:0]           push_count,
   output logic [ANGLE_BITS-1:0]             push_angle,
   output acsm_pkg::acsm_limits_type         limits
);
   import acsm_pkg::*;

   logic signed [ANGLE_BITS-1:0] angle_min_ff, angle_min_in;
   logic signed [ANGLE_BITS-1:0] angle_max_ff, angle_max_in;
   logic [LIMIT_BITS-1:0]        seq_limit_ff, seq_limit_in;
   logic [LIMIT_BITS-1:0]        rec_limit_ff, rec_limit_in;
   logic                         out_of_range;

   assign csr_ready = 1'b1;

   always_comb begin
      angle_min_in = angle_min_ff;
      angle_max_in = angle_max_ff;
      seq_limit_in = seq_limit_ff;
      rec_limit_in = rec_limit_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ANGLE_MIN: angle_min_in = csr_data;
            CSR_ANGLE_MAX: angle_max_in = csr_data;
            CSR_SEQ_LIMIT: seq_limit_in = csr_data[LIMIT_BITS-1:0];
            CSR_REC_LIMIT: rec_limit_in = csr_data[LIMIT_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_min_ff <= ANGLE_BITS'(ANGLE_MIN_RESET);
         angle_max_ff <= ANGLE_BITS'(ANGLE_MAX_RESET);
         seq_limit_ff <= SEQ_LIMIT_RESET;
         rec_limit_ff <= REC_LIMIT_RESET;
      end else begin
         angle_min_ff <= angle_min_in;
         angle_max_ff <= angle_max_in;
         seq_limit_ff <= seq_limit_in;
         rec_limit_ff <= rec_limit_in;
      end
   end

   assign limits.seq_limit = seq_limit_ff;
   assign limits.rec_limit = rec_limit_ff;

   // An empty range (min above max) flags every angle.
   assign out_of_range = (req_steer_angle_in < angle_min_ff) ||
                         (req_steer_angle_in > angle_max_ff);

   assign req_stall              = queue_full;
   assign queue_push             = req_valid && !req_stall;
   assign push_flags.rx_fault    = !req_rx_ok;
   assign push_flags.angle_fault = req_rx_ok && out_of_range;
   assign push_count             = req_alive_count_in;
   assign push_angle             = req_steer_angle_in;

endmodule

FILE: design/acsm_queue.sv
// Short register queue between the front and back ends.
// Depends on acsm_pkg.
module acsm_queue #(
   parameter int DATA_BITS = 2,
   parameter int DEPTH     = acsm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output logic [DATA_BITS-1:0] head_data
);
   import acsm_pkg::*;

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   LAST_PTR  = PTR_BITS'(DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] FULL_FILL = COUNT_BITS'(DEPTH);

   logic [DATA_BITS-1:0]  entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] fill_ff, fill_in;

   assign full      = (fill_ff == FULL_FILL);
   assign not_empty = (fill_ff != '0);
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/acsm_back.sv
// Back end: alive counter sequence tracking, mode control and result register.
// Depends on acsm_pkg.
module acsm_back #(
   parameter int COUNTER_BITS = acsm_pkg::COUNTER_BITS_DEFAULT,
   parameter int ANGLE_BITS   = acsm_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         entry_valid,
   output logic                         entry_pop,
   input  acsm_pkg::acsm_flags_type     entry_flags,
   input  logic [COUNTER_BITS-1:0]      entry_count,
   input  logic [ANGLE_BITS-1:0]        entry_angle,
   input  acsm_pkg::acsm_limits_type    limits,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [ANGLE_BITS-1:0] rsp_steer_angle_out,
   output logic                         rsp_fault_flag,
   output logic                         rsp_recovery_active,
   output logic                         rsp_rx_fault,
   output logic                         rsp_angle_fault
);
   import acsm_pkg::*;

   logic                    seen_ff, seen_in;
   logic                    recovery_ff, recovery_in;
   logic [COUNTER_BITS-1:0] last_ff, last_in;
   logic [LIMIT_BITS-1:0]   mismatch_ff, mismatch_in;
   logic [LIMIT_BITS-1:0]   good_ff, good_in;
   logic                    match;
   logic [LIMIT_BITS-1:0]   mismatch_sat;
   logic [LIMIT_BITS-1:0]   good_sat;

   logic                    valid_ff, valid_in;
   logic [ANGLE_BITS-1:0]   angle_ff;
   logic                    fault_ff, rec_out_ff, rx_fault_ff, angle_fault_ff;

   // The result register frees up when empty or when its transaction leaves.
   assign entry_pop = entry_valid && (!valid_ff || !rsp_stall);

   assign match        = (entry_count == COUNTER_BITS'(last_ff + 1'b1));
   assign mismatch_sat = (mismatch_ff < limits.seq_limit) ? mismatch_ff + 1'b1 : mismatch_ff;
   assign good_sat     = (good_ff < limits.rec_limit) ? good_ff + 1'b1 : good_ff;

   always_comb begin
      seen_in     = seen_ff;
      recovery_in = recovery_ff;
      last_in     = last_ff;
      mismatch_in = mismatch_ff;
      good_in     = good_ff;
      if (entry_pop) begin
         priority if (entry_flags.rx_fault) begin
            good_in = '0;
         end else if (!seen_ff) begin
            seen_in     = 1'b1;
            last_in     = entry_count;
            mismatch_in = '0;
            good_in     = '0;
         end else begin
            last_in = entry_count;
            priority if (!recovery_ff) begin
               if (match) begin
                  mismatch_in = '0;
               end else if (mismatch_sat >= limits.seq_limit) begin
                  recovery_in = 1'b1;
                  mismatch_in = '0;
                  good_in     = LIMIT_BITS'(1);
               end else begin
                  mismatch_in = mismatch_sat;
               end
            end else if (match) begin
               if (good_sat >= limits.rec_limit) begin
                  recovery_in = 1'b0;
                  mismatch_in = '0;
                  good_in     = '0;
               end else begin
                  good_in = good_sat;
               end
            end else begin
               good_in = LIMIT_BITS'(1);
            end
         end
      end
   end

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      if (entry_pop) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= 1'b0;
         recovery_ff <= 1'b0;
         last_ff     <= '0;
         mismatch_ff <= '0;
         good_ff     <= '0;
         valid_ff    <= 1'b0;
      end else begin
         seen_ff     <= seen_in;
         recovery_ff <= recovery_in;
         last_ff     <= last_in;
         mismatch_ff <= mismatch_in;
         good_ff     <= good_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_pop) begin
         angle_ff       <= entry_angle;
         rec_out_ff     <= recovery_in;
         rx_fault_ff    <= entry_flags.rx_fault;
         angle_fault_ff <= entry_flags.angle_fault;
         fault_ff       <= recovery_in || entry_flags.rx_fault || entry_flags.angle_fault;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_steer_angle_out = angle_ff;
   assign rsp_fault_flag      = fault_ff;
   assign rsp_recovery_active = rec_out_ff;
   assign rsp_rx_fault        = rx_fault_ff;
   assign rsp_angle_fault     = angle_fault_ff;

endmodule

FILE: design/acsm_checker.sv
// Port-level assertions for the alive counter sequence monitor, with its bind.
// Depends on acsm_pkg and the assertion macro header.
`include "alive_counter_sequence_monitor_unit_defines.svh"

module acsm_checker #(
   parameter int ANGLE_BITS = acsm_pkg::ANGLE_BITS_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [ANGLE_BITS-1:0] rsp_steer_angle_out,
   input logic                         rsp_fault_flag,
   input logic                         rsp_recovery_active,
   input logic                         rsp_rx_fault,
   input logic                         rsp_angle_fault
);

   logic                  fault_cause;
   logic [ANGLE_BITS+3:0] rsp_payload;

   assign fault_cause = rsp_recovery_active || rsp_rx_fault || rsp_angle_fault;
   assign rsp_payload = {rsp_steer_angle_out, rsp_fault_flag, rsp_recovery_active,
                         rsp_rx_fault, rsp_angle_fault};

   // The summary flag is exactly the OR of the three causes.
   `ACSM_ASSERT_NOW(a_fault_is_or, rsp_valid, rsp_fault_flag == fault_cause)

   // A failed reception never reports an angle fault.
   `ACSM_ASSERT_NOW(a_rx_fault_no_angle, rsp_valid && rsp_rx_fault, !rsp_angle_fault)

   // A stalled response transaction stays in place unchanged.
   `ACSM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind alive_counter_sequence_monitor_unit acsm_checker #(
   .ANGLE_BITS (ANGLE_BITS)
) u_acsm_checker (.*);
